// File: rtl/microwire_eeprom_master_assert.svh
// ----------------------------------------------------------------------------
// microwire eeprom master assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef MICROWIRE_EEPROM_MASTER_ASSERT_SVH
`define MICROWIRE_EEPROM_MASTER_ASSERT_SVH

// same-cycle implication
`define MWEM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MWEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mwem_pkg.sv
// ----------------------------------------------------------------------------
// mwem_pkg
// types and constants shared by the microwire eeprom master
// ----------------------------------------------------------------------------
package mwem_pkg;

    localparam int ADDR_BITS_DEF = 9;
    localparam int DATA_BITS_DEF = 8;
    localparam int REQ_ADDR_W    = 9;
    localparam int REQ_DATA_W    = 8;
    localparam int RD_DATA_W     = 8;
    localparam logic [7:0] HALF_RST = 8'd4;

    // request kinds
    typedef enum logic [2:0] {
        REQ_READ  = 3'd0,
        REQ_WRITE = 3'd1,
        REQ_ERASE = 3'd2,
        REQ_ERAL  = 3'd3,
        REQ_WRAL  = 3'd4
    } t_req_type;

    // two-bit opcodes after the start bit
    localparam logic [1:0] OPC_EXT   = 2'b00;
    localparam logic [1:0] OPC_WRITE = 2'b01;
    localparam logic [1:0] OPC_READ  = 2'b10;
    localparam logic [1:0] OPC_ERASE = 2'b11;

    // top two address bits of the extended opcodes
    localparam logic [1:0] EXT_EWDS = 2'b00;
    localparam logic [1:0] EXT_WRAL = 2'b01;
    localparam logic [1:0] EXT_ERAL = 2'b10;
    localparam logic [1:0] EXT_EWEN = 2'b11;

    // one tick worth of input
    typedef struct packed {
        logic                  req_valid;
        logic [2:0]            req_type;
        logic [REQ_ADDR_W-1:0] req_addr;
        logic [REQ_DATA_W-1:0] req_data;
        logic                  dout_pin;
    } t_mw_req;

    // one tick worth of pin levels and status
    typedef struct packed {
        logic                 cs_pin;
        logic                 sk_pin;
        logic                 di_pin;
        logic                 busy_res;
        logic                 done_res;
        logic [RD_DATA_W-1:0] read_data;
    } t_mw_res;

endpackage

// File: rtl/mwem_seq.sv
// ----------------------------------------------------------------------------
// mwem_seq
// pin sequencer: state registers plus the logic of one tick
// ----------------------------------------------------------------------------
`include "microwire_eeprom_master_assert.svh"

module mwem_seq #(
    parameter int ADDR_BITS = mwem_pkg::ADDR_BITS_DEF,
    parameter int DATA_BITS = mwem_pkg::DATA_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  mwem_pkg::t_mw_req i_req,
    input  logic [7:0]       i_half,
    output mwem_pkg::t_mw_res o_res
);
    import mwem_pkg::*;

    localparam int FRAME_W = 3 + ADDR_BITS + DATA_BITS;
    localparam int CNT_W   = $clog2(FRAME_W + 1);
    localparam int IDX_W   = $clog2(FRAME_W);

    typedef enum logic [2:0] {
        PH_IDLE, PH_CSON, PH_SKHI, PH_SKLO, PH_CSOFF, PH_POLL
    } t_phase;

    typedef enum logic [1:0] {
        ST_EWEN, ST_MAIN, ST_WAIT, ST_EWDS
    } t_stage;

    typedef struct packed {
        logic [CNT_W-1:0]   len;
        logic [FRAME_W-1:0] bits;
    } t_frame;

    // command frame for a stage of a request
    function automatic t_frame build_frame(
        input t_stage                 stg,
        input t_req_type              op,
        input logic [REQ_ADDR_W-1:0]  addr,
        input logic [REQ_DATA_W-1:0]  data
    );
        logic [ADDR_BITS-1:0]   a;
        logic [DATA_BITS-1:0]   d;
        logic [ADDR_BITS+2:0]   cmd;
        logic                   has_data;
        t_frame                 f;
        a        = ADDR_BITS'(addr);
        d        = (op == REQ_READ) ? '0 : DATA_BITS'(data);
        has_data = 1'b0;
        if (stg == ST_EWEN) begin
            cmd = {1'b1, OPC_EXT, EXT_EWEN, {(ADDR_BITS-2){1'b0}}};
        end else if (stg == ST_EWDS) begin
            cmd = {1'b1, OPC_EXT, EXT_EWDS, {(ADDR_BITS-2){1'b0}}};
        end else begin
            case (op)
                REQ_READ: begin
                    cmd      = {1'b1, OPC_READ, a};
                    has_data = 1'b1;
                end
                REQ_WRITE: begin
                    cmd      = {1'b1, OPC_WRITE, a};
                    has_data = 1'b1;
                end
                REQ_ERASE: cmd = {1'b1, OPC_ERASE, a};
                REQ_ERAL:  cmd = {1'b1, OPC_EXT, EXT_ERAL, {(ADDR_BITS-2){1'b0}}};
                default: begin
                    cmd      = {1'b1, OPC_EXT, EXT_WRAL, {(ADDR_BITS-2){1'b0}}};
                    has_data = 1'b1;
                end
            endcase
        end
        if (has_data) begin
            f.bits = {cmd, d};
            f.len  = CNT_W'(FRAME_W);
        end else begin
            f.bits = FRAME_W'(cmd);
            f.len  = CNT_W'(3 + ADDR_BITS);
        end
        return f;
    endfunction

    t_phase                r_phase, n_phase, e_phase;
    t_stage                r_stage, n_stage, e_stage, stage_inc;
    t_req_type             r_op, e_op;
    logic [REQ_ADDR_W-1:0] r_addr, e_addr;
    logic [REQ_DATA_W-1:0] r_data, e_data;
    logic [FRAME_W-1:0]    r_shift, n_shift, e_shift;
    logic [CNT_W-1:0]      r_bit_count, n_bit_count, e_bit_count, bc_m1;
    logic [RD_DATA_W-1:0]  r_in_shift, n_in_shift;
    logic [7:0]            r_tick, n_tick, e_tick;
    logic [7:0]            half_eff;
    logic                  hold_end, start;
    t_frame                frame_new, frame_next;
    t_mw_res               res;

    assign half_eff   = (i_half == 8'd0) ? 8'd1 : i_half;
    assign start      = (r_phase == PH_IDLE) && i_req.req_valid
                        && (i_req.req_type <= REQ_WRAL);
    assign e_phase    = start ? PH_CSON : r_phase;
    assign e_op       = start ? t_req_type'(i_req.req_type) : r_op;
    assign e_addr     = start ? i_req.req_addr : r_addr;
    assign e_data     = start ? i_req.req_data : r_data;
    assign e_stage    = start ? ((i_req.req_type == REQ_READ) ? ST_MAIN : ST_EWEN)
                              : r_stage;
    assign frame_new  = build_frame(e_stage, e_op, e_addr, e_data);
    assign e_shift    = start ? frame_new.bits : r_shift;
    assign e_bit_count = start ? frame_new.len : r_bit_count;
    assign e_tick     = start ? 8'd0 : r_tick;
    assign hold_end   = ({1'b0, e_tick} + 9'd1) >= {1'b0, half_eff};
    assign stage_inc  = t_stage'(2'(e_stage) + 2'd1);
    assign frame_next = build_frame(stage_inc, e_op, e_addr, e_data);
    assign bc_m1      = e_bit_count - CNT_W'(1);

    always_comb begin
        n_phase     = e_phase;
        n_stage     = e_stage;
        n_shift     = e_shift;
        n_bit_count = e_bit_count;
        n_in_shift  = r_in_shift;
        n_tick      = e_tick;
        res         = '0;
        res.busy_res = (e_phase != PH_IDLE);
        case (e_phase)
            PH_CSON: begin
                res.cs_pin = 1'b1;
                if (hold_end) begin
                    n_tick  = 8'd0;
                    n_phase = (e_stage == ST_WAIT) ? PH_POLL : PH_SKHI;
                end else begin
                    n_tick = e_tick + 8'd1;
                end
            end
            PH_SKHI: begin
                res.cs_pin = 1'b1;
                res.sk_pin = 1'b1;
                if (e_bit_count != '0) begin
                    res.di_pin = e_shift[bc_m1[IDX_W-1:0]];
                end
                if (hold_end) begin
                    n_tick     = 8'd0;
                    n_in_shift = {r_in_shift[RD_DATA_W-2:0], i_req.dout_pin};
                    n_phase    = PH_SKLO;
                end else begin
                    n_tick = e_tick + 8'd1;
                end
            end
            PH_SKLO: begin
                res.cs_pin = 1'b1;
                if (hold_end) begin
                    n_tick = 8'd0;
                    if (e_bit_count != '0) begin
                        n_bit_count = bc_m1;
                    end
                    n_phase = (n_bit_count != '0) ? PH_SKHI : PH_CSOFF;
                end else begin
                    n_tick = e_tick + 8'd1;
                end
            end
            PH_POLL: begin
                res.cs_pin = 1'b1;
                if (i_req.dout_pin) begin
                    n_tick  = 8'd0;
                    n_phase = PH_CSOFF;
                end
            end
            PH_CSOFF: begin
                if (hold_end) begin
                    n_tick = 8'd0;
                    if (e_op == REQ_READ || e_stage == ST_EWDS) begin
                        res.done_res = 1'b1;
                        if (e_op == REQ_READ) begin
                            res.read_data = r_in_shift;
                        end
                        n_phase = PH_IDLE;
                    end else begin
                        n_stage = stage_inc;
                        if (stage_inc != ST_WAIT) begin
                            n_shift     = frame_next.bits;
                            n_bit_count = frame_next.len;
                        end
                        n_phase = PH_CSON;
                    end
                end else begin
                    n_tick = e_tick + 8'd1;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_stage     <= ST_EWEN;
            r_op        <= REQ_READ;
            r_addr      <= '0;
            r_data      <= '0;
            r_shift     <= '0;
            r_bit_count <= '0;
            r_in_shift  <= '0;
            r_tick      <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_stage     <= n_stage;
            r_op        <= e_op;
            r_addr      <= e_addr;
            r_data      <= e_data;
            r_shift     <= n_shift;
            r_bit_count <= n_bit_count;
            r_in_shift  <= n_in_shift;
            r_tick      <= n_tick;
        end
    end

    `MWEM_ASSERT_NOW(a_sk_needs_cs, res.sk_pin, res.cs_pin, "sk high with cs low")
    `MWEM_ASSERT_NEXT(a_done_to_idle, i_step && res.done_res, r_phase == PH_IDLE,
        "done without return to idle")
    `MWEM_ASSERT_NOW(a_rdata_only_read, res.read_data != '0,
        res.done_res && e_op == REQ_READ, "read data outside read completion")
    `MWEM_ASSERT_NOW(a_count_bound, 1'b1, r_bit_count <= CNT_W'(FRAME_W),
        "bit count beyond frame length")

endmodule

// File: rtl/microwire_eeprom_master.sv
// ----------------------------------------------------------------------------
// microwire eeprom master
// tick-driven microwire master with stream input, stream result, config write
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: req_valid, addr, data, dout
//                                                tuser: req_type
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: pins, busy, done, read_data
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_data: half period in ticks
//
// one word per clock cycle while the result side does not stall; each input word is one sequencer tick
// each accepted input word passes the input register, then the result register
// a stalled result register holds the input register, which in turn holds
// s_axis_tready low; no word is dropped or repeated
// synchronous active-low reset: idle, pins low, half period 4
// ----------------------------------------------------------------------------
module microwire_eeprom_master #(
    parameter int ADDR_BITS = mwem_pkg::ADDR_BITS_DEF,
    parameter int DATA_BITS = mwem_pkg::DATA_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words, one per tick
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // req_valid, req_addr[8:0], req_data[7:0],
                                       // dout_pin, zero pad
    input  logic [2:0]  s_axis_tuser,  // req_type
    // result words, one per tick
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // cs_pin, sk_pin, di_pin, busy_res, done_res,
                                       // read_data[7:0], zero pad
    // half period register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import mwem_pkg::*;

    logic    r_in_vld;
    t_mw_req r_in;
    logic    r_out_vld;
    t_mw_res r_out;
    logic [7:0] r_half;
    logic    in_take, advance;
    t_mw_res res;

    // a tick advances when an input word is held and the result register is free or being drained
    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_half    <= HALF_RST;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_half <= i_cfg_data;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.req_valid <= s_axis_tdata[0];
            r_in.req_type  <= s_axis_tuser;
            r_in.req_addr  <= s_axis_tdata[9:1];
            r_in.req_data  <= s_axis_tdata[17:10];
            r_in.dout_pin  <= s_axis_tdata[18];
        end
        if (advance) begin
            r_out <= res;
        end
    end

    mwem_seq #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_req   (r_in),
        .i_half  (r_half),
        .o_res   (res)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out.read_data, r_out.done_res, r_out.busy_res,
                            r_out.di_pin, r_out.sk_pin, r_out.cs_pin};

endmodule

// File: test/microwire_eeprom_master_tb.sv
// ----------------------------------------------------------------------------
// microwire_eeprom_master_tb
// drives tick words into the microwire master and checks every result word
// against an in-bench model of the pin sequencer, over several half periods
// and several idle and stall patterns on both stream sides
// ----------------------------------------------------------------------------
module microwire_eeprom_master_tb;

    import mwem_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    // sequencer phases and frame stages of the in-bench model
    typedef enum logic [2:0] {
        SQ_IDLE, SQ_CSON, SQ_SKHI, SQ_SKLO, SQ_CSOFF, SQ_POLL
    } t_seq_phase;

    typedef enum logic [1:0] {
        FR_EWEN, FR_MAIN, FR_WAIT, FR_EWDS
    } t_frame_stage;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // req_valid, req_addr[8:0], req_data[7:0], dout_pin, zero pad
    logic [2:0]  s_axis_tuser;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // cs_pin, sk_pin, di_pin, busy_res, done_res,
                                 // read_data[7:0], zero pad
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    microwire_eeprom_master dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_mw_req tick_words_q[$];      // words waiting for the driver
    t_mw_res tick_results_q[$];    // predicted result words, oldest first
    t_mw_req drv_word;             // word currently on s_axis

    int unsigned n_pushed;
    int unsigned n_driven;
    int unsigned n_accepted;
    int unsigned n_checked;
    int unsigned n_cfg;
    int unsigned cyc;
    int          errors;
    int          gap_pct;
    int          stall_pct;

    // dout pin pattern: runs of one level, or a forced level
    int          dout_force;
    logic        dout_level;
    int          dout_left;

    // model state
    logic [7:0]   half_reg;
    t_seq_phase   seq_phase;
    t_frame_stage seq_stage;
    logic [4:0]   bits_left;
    logic [19:0]  frame_bits;
    logic [7:0]   sampled;
    logic [7:0]   hold_cnt;
    t_req_type    held_kind;
    logic [8:0]   held_addr;
    logic [7:0]   held_data;
    int unsigned  taken_cnt[8];

    // ------------------------------------------------------------------------
    // model of the sequencer
    // ------------------------------------------------------------------------

    // build the next frame from the held request and the stage
    function automatic void load_frame();
        logic [1:0]  opc;
        logic [8:0]  a;
        logic [11:0] cmd;
        logic        has_data;
        has_data = 1'b0;
        a        = '0;
        opc      = OPC_EXT;
        if (seq_stage == FR_EWEN) begin
            a = {EXT_EWEN, 7'd0};
        end else if (seq_stage == FR_EWDS) begin
            a = {EXT_EWDS, 7'd0};
        end else begin
            case (held_kind)
                REQ_READ:  begin opc = OPC_READ;  a = held_addr; has_data = 1'b1; end
                REQ_WRITE: begin opc = OPC_WRITE; a = held_addr; has_data = 1'b1; end
                REQ_ERASE: begin opc = OPC_ERASE; a = held_addr; end
                REQ_ERAL:  begin a = {EXT_ERAL, 7'd0}; end
                default:   begin a = {EXT_WRAL, 7'd0}; has_data = 1'b1; end
            endcase
        end
        cmd = {1'b1, opc, a};
        if (has_data) begin
            // a read drives DI low while data is clocked in
            frame_bits = {cmd, (held_kind == REQ_READ) ? 8'd0 : held_data};
            bits_left  = 5'd20;
        end else begin
            frame_bits = {8'd0, cmd};
            bits_left  = 5'd12;
        end
    endfunction

    // one tick of the pin sequencer
    function automatic t_mw_res sequencer_tick(input t_mw_req w);
        t_mw_res r;
        int      h;
        logic    hold_end;
        r = '0;
        h = (half_reg == 8'd0) ? 1 : int'(half_reg);

        // a request is taken only from idle, and only for a known kind
        if (seq_phase == SQ_IDLE && w.req_valid && w.req_type <= REQ_WRAL) begin
            held_kind = t_req_type'(w.req_type);
            held_addr = w.req_addr;
            held_data = w.req_data;
            seq_stage = (held_kind == REQ_READ) ? FR_MAIN : FR_EWEN;
            load_frame();
            hold_cnt  = '0;
            seq_phase = SQ_CSON;
            taken_cnt[w.req_type]++;
        end

        r.busy_res = (seq_phase != SQ_IDLE);
        // the hold ends once the count plus one reaches the current half period (zero acts as one)
        hold_end = (int'(hold_cnt) + 1 >= h);

        case (seq_phase)
            SQ_CSON: begin
                r.cs_pin = 1'b1;
                if (hold_end) begin
                    hold_cnt  = '0;
                    seq_phase = (seq_stage == FR_WAIT) ? SQ_POLL : SQ_SKHI;
                end else begin
                    hold_cnt++;
                end
            end
            SQ_SKHI: begin
                r.cs_pin = 1'b1;
                r.sk_pin = 1'b1;
                if (bits_left != 0)
                    r.di_pin = frame_bits[bits_left - 5'd1];
                if (hold_end) begin
                    hold_cnt  = '0;
                    sampled   = {sampled[6:0], w.dout_pin};
                    seq_phase = SQ_SKLO;
                end else begin
                    hold_cnt++;
                end
            end
            SQ_SKLO: begin
                r.cs_pin = 1'b1;
                if (hold_end) begin
                    hold_cnt = '0;
                    if (bits_left != 0)
                        bits_left--;
                    seq_phase = (bits_left != 0) ? SQ_SKHI : SQ_CSOFF;
                end else begin
                    hold_cnt++;
                end
            end
            SQ_POLL: begin
                // ready wait, no timeout
                r.cs_pin = 1'b1;
                if (w.dout_pin) begin
                    hold_cnt  = '0;
                    seq_phase = SQ_CSOFF;
                end
            end
            SQ_CSOFF: begin
                if (hold_end) begin
                    hold_cnt = '0;
                    if (held_kind == REQ_READ || seq_stage == FR_EWDS) begin
                        r.done_res = 1'b1;
                        if (held_kind == REQ_READ)
                            r.read_data = sampled;
                        seq_phase = SQ_IDLE;
                    end else begin
                        seq_stage = t_frame_stage'(seq_stage + 1);
                        if (seq_stage != FR_WAIT)
                            load_frame();
                        seq_phase = SQ_CSON;
                    end
                end else begin
                    hold_cnt++;
                end
            end
            default: seq_phase = SQ_IDLE;
        endcase
        return r;
    endfunction

    function automatic void cmp_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver: presents queued tick words and sets the result side ready,
    // both at the falling edge, with recurring quiet stretches free of gaps
    // and stalls
    always @(negedge i_clk) begin
        logic calm;
        calm = (cyc % 200) < 30;
        if (n_accepted == n_driven) begin
            // previous word taken (or none was out), pick the next one
            if (tick_words_q.size() != 0 && !(!calm && $urandom_range(0, 99) < gap_pct)) begin
                drv_word = tick_words_q.pop_front();
                n_driven++;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {5'd0, drv_word.dout_pin, drv_word.req_data,
                                  drv_word.req_addr, drv_word.req_valid};
                s_axis_tuser  <= drv_word.req_type;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= !(!calm && $urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // monitor: checks each result word, then runs the model on each accepted
    // input word; the two can not refer to the same word (the input register
    // and the result register lie between)
    always @(posedge i_clk) begin
        t_mw_res want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (tick_results_q.size() == 0) begin
                    $error("result word with no prediction pending");
                    errors++;
                end else begin
                    want = tick_results_q.pop_front();
                    cmp_field("cs_pin",    int'(want.cs_pin),    int'(m_axis_tdata[0]));
                    cmp_field("sk_pin",    int'(want.sk_pin),    int'(m_axis_tdata[1]));
                    cmp_field("di_pin",    int'(want.di_pin),    int'(m_axis_tdata[2]));
                    cmp_field("busy_res",  int'(want.busy_res),  int'(m_axis_tdata[3]));
                    cmp_field("done_res",  int'(want.done_res),  int'(m_axis_tdata[4]));
                    cmp_field("read_data", int'(want.read_data), int'(m_axis_tdata[12:5]));
                    n_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                tick_results_q.push_back(sequencer_tick(drv_word));
                n_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // queue one tick word; dout follows runs of random length and level, or the forced level
    task automatic push_tick(input logic v, input logic [2:0] kind,
                             input logic [8:0] addr, input logic [7:0] data);
        t_mw_req w;
        if (dout_left == 0) begin
            dout_level = 1'($urandom_range(0, 1));
            dout_left  = $urandom_range(1, 12);
        end
        dout_left--;
        w.req_valid = v;
        w.req_type  = kind;
        w.req_addr  = addr;
        w.req_data  = data;
        w.dout_pin  = (dout_force < 0) ? dout_level : dout_force[0];
        tick_words_q.push_back(w);
        n_pushed++;
    endtask

    task automatic drain();
        while (n_accepted != n_pushed || tick_results_q.size() != 0)
            @(negedge i_clk);
    endtask

    // register write only with nothing in flight; the model may still be busy,
    // which exercises a half period change in the middle of a hold
    task automatic write_half(input logic [7:0] v);
        drain();
        repeat (3) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        half_reg = v;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // feed empty ticks until the model is idle, then offer the request
    task automatic issue(input logic [2:0] kind, input logic [8:0] addr,
                         input logic [7:0] data);
        logic idle;
        idle = 1'b0;
        while (!idle) begin
            @(negedge i_clk);
            if (n_accepted == n_pushed) begin
                if (seq_phase == SQ_IDLE)
                    idle = 1'b1;
                else
                    push_tick(1'b0, REQ_READ, '0, '0);
            end
        end
        push_tick(1'b1, kind, addr, data);
    endtask

    // random ticks: sparse requests, mostly known kinds, some unknown ones
    task automatic random_ticks(input int n);
        logic [2:0] kind;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 9)
                kind = 3'($urandom_range(REQ_READ, REQ_WRAL));
            else
                kind = 3'($urandom_range(REQ_WRAL + 1, 7));
            push_tick($urandom_range(0, 15) == 0, kind,
                      9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        drv_word      = '0;
        gap_pct       = 0;
        stall_pct     = 0;
        dout_force    = -1;
        dout_level    = 1'b0;
        dout_left     = 0;
        half_reg      = HALF_RST;
        seq_phase     = SQ_IDLE;
        seq_stage     = FR_EWEN;
        bits_left     = '0;
        frame_bits    = '0;
        sampled       = '0;
        hold_cnt      = '0;
        held_kind     = REQ_READ;
        held_addr     = '0;
        held_data     = '0;

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part at the shortest half period, no idling
        write_half(8'd1);
        dout_force = 1;
        issue(REQ_READ, 9'h1ff, 8'h00);
        push_tick(1'b1, REQ_WRITE, 9'h000, 8'hff);   // offered while busy, dropped
        dout_force = 0;
        issue(REQ_READ, 9'h000, 8'hff);
        dout_force = -1;
        issue(REQ_WRITE, 9'h1ff, 8'hff);
        issue(REQ_WRITE, 9'h000, 8'h00);
        issue(REQ_ERASE, 9'h155, 8'h5a);
        issue(REQ_ERAL,  9'h0aa, 8'h3c);
        issue(REQ_WRAL,  9'h0aa, 8'ha5);
        for (int k = REQ_WRAL + 1; k < 8; k++)
            issue(k[2:0], 9'h1ff, 8'hff);         // unknown kinds, stays idle
        issue(REQ_READ, 9'h0f0, 8'h0f);

        // random part, one idling pattern per half period
        write_half(8'd0);                          // zero acts as one
        random_ticks(150);

        write_half(8'd1);
        gap_pct = 87;
        random_ticks(150);

        write_half(8'd2);
        gap_pct   = 0;
        stall_pct = 87;
        random_ticks(150);

        write_half(8'($urandom_range(1, 3)));
        gap_pct   = 13;
        stall_pct = 13;
        random_ticks(150);

        // longest half period, then cut short in the middle of a hold
        write_half(8'd255);
        gap_pct   = 0;
        stall_pct = 0;
        push_tick(1'b1, REQ_WRITE, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
        random_ticks(50);
        write_half(8'd1);
        random_ticks(100);

        drain();
        repeat (8) @(posedge i_clk);
        if (tick_results_q.size() != 0) begin
            $error("%0d predicted result words never arrived", tick_results_q.size());
            errors++;
        end

        $display("checked %0d result words over %0d register writes (half period 0 to 255)",
                 n_checked, n_cfg);
        $display("requests taken: read %0d, write %0d, erase %0d, erase-all %0d, fill-all %0d",
                 taken_cnt[REQ_READ], taken_cnt[REQ_WRITE], taken_cnt[REQ_ERASE],
                 taken_cnt[REQ_ERAL], taken_cnt[REQ_WRAL]);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
